@@ rtl/water_ripple_stencil_step_defines.svh @@
// ----------------------------------------------------------------------------
// water ripple stencil step assertion macros
// shared concurrent assertion wrappers for the ripple stencil rtl
// ----------------------------------------------------------------------------
`ifndef WATER_RIPPLE_STENCIL_STEP_DEFINES_SVH
`define WATER_RIPPLE_STENCIL_STEP_DEFINES_SVH

// assertion checked on rising clock, masked while reset is high
`define WRS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion checked on every rising clock, reset included
`define WRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/wrs_pkg.sv @@
// ----------------------------------------------------------------------------
// wrs_pkg
// shared constants, types and helpers of the water ripple stencil step
// ----------------------------------------------------------------------------
`default_nettype none

package wrs_pkg;

   // geometry and data widths
   localparam int WIDTH_MAX   = 1024;
   localparam int ROWS_MAX    = 1024;
   localparam int COL_BITS    = $clog2(WIDTH_MAX);
   localparam int ROW_BITS    = $clog2(ROWS_MAX);
   localparam int SIZE_BITS   = 11;
   localparam int HEIGHT_BITS = 16;
   localparam int DAMP_BITS   = 16;
   localparam int SIZE_MIN    = 3;

   // stencil arithmetic widths
   localparam int DIFF_BITS = HEIGHT_BITS + 2;
   localparam int PROD_BITS = DIFF_BITS + DAMP_BITS + 1;
   localparam int SAT_HI    = 2 ** (HEIGHT_BITS - 1) - 1;
   localparam int SAT_LO    = -(2 ** (HEIGHT_BITS - 1));

   // register map
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_FRAME_WIDTH  = 2'd0,
      REG_FRAME_HEIGHT = 2'd1,
      REG_DAMPING      = 2'd2
   } reg_index_type;

   // register reset values
   localparam logic [SIZE_BITS-1:0] FRAME_WIDTH_RST  = SIZE_BITS'(640);
   localparam logic [SIZE_BITS-1:0] FRAME_HEIGHT_RST = SIZE_BITS'(480);
   localparam logic [DAMP_BITS-1:0] DAMPING_RST      = DAMP_BITS'(61604);

   typedef logic signed [HEIGHT_BITS-1:0] height_type;
   typedef logic [COL_BITS-1:0]           col_type;
   typedef logic [ROW_BITS-1:0]           row_type;
   typedef logic [SIZE_BITS-1:0]          size_type;
   typedef logic signed [DIFF_BITS-1:0]   diff_type;
   typedef logic signed [PROD_BITS-1:0]   prod_type;

   // neighborhood of one output pixel as read from the line buffers
   typedef struct packed {
      height_type left;
      height_type right;
      height_type up;
      height_type prev;
   } window_type;

   // per-item control flags that travel down the pipe
   typedef struct packed {
      logic interior;
      logic last;
   } flag_type;

   typedef struct packed {
      flag_type   flags;
      height_type border;
   } ctl_type;

   // clamp a frame size register into the supported range
   function automatic size_type clamp_size(input size_type v, input int hi);
      size_type r;
      r = v;
      if (v < SIZE_BITS'(SIZE_MIN)) begin
         r = SIZE_BITS'(SIZE_MIN);
      end else if (v > SIZE_BITS'(hi)) begin
         r = SIZE_BITS'(hi);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/water_ripple_stencil_step.sv @@
// ----------------------------------------------------------------------------
// water_ripple_stencil_step
// one update step of a two-buffer water ripple height field, raster streamed
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | tdata: cur_height, prev_height
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata: new_height, tlast: last_of_frame
//  csr     | in  | csr_valid/csr_ready    | csr_index, csr_wdata
//
//  one pixel per clock unless the response side stalls; a result passes through the
//  line buffer read, stencil, multiply and output registers
//  pixels of the first row of a frame give no result
//  row buffers are not cleared by reset; counters restart at the frame origin
//  each stage holds while the stage after it is full and stalled, bubbles close
//  csr_ready is always high
// ----------------------------------------------------------------------------
`default_nettype none

`include "water_ripple_stencil_step_defines.svh"

module water_ripple_stencil_step (
   input  wire         clock,
   input  wire         reset,
   // request: [15:0] cur_height, [31:16] prev_height
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,
   // response: [15:0] new_height
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast,
   // configuration write channel
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [wrs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire  [wrs_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int HB = wrs_pkg::HEIGHT_BITS;

   // configuration registers
   wrs_pkg::size_type              frame_width_ff;
   wrs_pkg::size_type              frame_height_ff;
   logic [wrs_pkg::DAMP_BITS-1:0]  damping_ff;

   // raster position
   wrs_pkg::col_type col_ff, col_in;
   wrs_pkg::row_type row_ff, row_in;

   wrs_pkg::size_type   width_c;
   wrs_pkg::size_type   height_c;
   logic                row_end;
   logic                frame_end;
   logic                accept;
   wrs_pkg::flag_type   flags_in;
   wrs_pkg::height_type cur_height;
   wrs_pkg::height_type prev_height;

   // pipeline valids and enables
   logic v1_ff, v2_ff, v3_ff;
   logic en1, en2, en3, en_out;

   wrs_pkg::flag_type   flags1_ff;
   wrs_pkg::height_type down1_ff;
   wrs_pkg::ctl_type    ctl2_ff;
   wrs_pkg::ctl_type    ctl3_ff;

   wrs_pkg::window_type window;
   wrs_pkg::diff_type   diff;
   wrs_pkg::height_type damped;

   logic                rsp_valid_ff;
   wrs_pkg::height_type rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff;

   assign cur_height  = req_tdata[HB-1:0];
   assign prev_height = req_tdata[2*HB-1:HB];

   // configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= wrs_pkg::FRAME_WIDTH_RST;
         frame_height_ff <= wrs_pkg::FRAME_HEIGHT_RST;
         damping_ff      <= wrs_pkg::DAMPING_RST;
      end else if (csr_valid && csr_ready) begin
         case (wrs_pkg::reg_index_type'(csr_index))
            wrs_pkg::REG_FRAME_WIDTH: begin
               frame_width_ff <= csr_wdata[wrs_pkg::SIZE_BITS-1:0];
            end
            wrs_pkg::REG_FRAME_HEIGHT: begin
               frame_height_ff <= csr_wdata[wrs_pkg::SIZE_BITS-1:0];
            end
            wrs_pkg::REG_DAMPING: begin
               damping_ff <= csr_wdata[wrs_pkg::DAMP_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // stall control, each stage loads when empty or when the next one moves
   assign en_out     = !rsp_valid_ff || rsp_tready;
   assign en3        = !v3_ff || en_out;
   assign en2        = !v2_ff || en3;
   assign en1        = !v1_ff || en2;
   assign req_tready = en1;
   assign accept     = req_tvalid && req_tready;

   // raster position decode
   always_comb begin
      width_c   = wrs_pkg::clamp_size(frame_width_ff, wrs_pkg::WIDTH_MAX);
      height_c  = wrs_pkg::clamp_size(frame_height_ff, wrs_pkg::ROWS_MAX);
      row_end   = ({1'b0, col_ff} + wrs_pkg::SIZE_BITS'(1)) >= width_c;
      frame_end = ({1'b0, row_ff} + wrs_pkg::SIZE_BITS'(1)) >= height_c;
      flags_in.interior = (col_ff != '0) && !row_end
                        && (row_ff >= wrs_pkg::ROW_BITS'(2));
      flags_in.last     = row_end && frame_end;
      col_in = col_ff;
      row_in = row_ff;
      if (row_end) begin
         col_in = '0;
         row_in = frame_end ? '0 : row_ff + wrs_pkg::ROW_BITS'(1);
      end else begin
         col_in = col_ff + wrs_pkg::COL_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line buffers and window read
   wrs_line_buf u_line_buf (
      .clock       (clock),
      .rd_en       (en1),
      .wr_en       (accept),
      .col         (col_ff),
      .row_odd     (row_ff[0]),
      .cur_height  (cur_height),
      .prev_height (prev_height),
      .window      (window)
   );

   // stage 1 control, alongside the window read
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= accept && (row_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         flags1_ff <= flags_in;
         down1_ff  <= cur_height;
      end
   end

   // stage 2, stencil difference
   wrs_stencil u_stencil (
      .clock  (clock),
      .en     (en2),
      .window (window),
      .down   (down1_ff),
      .diff   (diff)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         ctl2_ff.flags  <= flags1_ff;
         ctl2_ff.border <= window.prev;
      end
   end

   // stage 3, damping product
   wrs_damp u_damp (
      .clock   (clock),
      .en      (en3),
      .diff    (diff),
      .damping (damping_ff),
      .height  (damped)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         ctl3_ff <= ctl2_ff;
      end
   end

   // output register, border pixels pass the previous height
   assign rsp_data_in = ctl3_ff.flags.interior ? damped : ctl3_ff.border;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_out) begin
         rsp_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= ctl3_ff.flags.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // a full stage that cannot move keeps its item
   `WRS_ASSERT(a_stage1_hold, clock, reset, (v1_ff && !en2) |=> v1_ff, "stage 1 item dropped")

   // a transaction past the first row always enters the pipe
   `WRS_ASSERT(a_emit_enter, clock, reset, (accept && (row_ff != '0)) |=> v1_ff, "result item lost")

   // the last pixel of a frame returns the raster to its origin
   `WRS_ASSERT(a_frame_wrap, clock, reset, (accept && flags_in.last) |=> ((col_ff == '0) && (row_ff == '0)), "raster did not wrap")

endmodule

`default_nettype wire

@@ rtl/wrs_line_buf.sv @@
// ----------------------------------------------------------------------------
// wrs_line_buf
// row buffers of the current frame (even and odd rows) and of the previous
// frame, with registered read ports that form the stencil window
// ----------------------------------------------------------------------------
`default_nettype none

module wrs_line_buf (
   input  wire                     clock,
   input  wire                     rd_en,
   input  wire                     wr_en,
   input  wrs_pkg::col_type        col,
   input  wire                     row_odd,
   input  wrs_pkg::height_type     cur_height,
   input  wrs_pkg::height_type     prev_height,
   output wrs_pkg::window_type     window
);

   // row memories: row y goes into mem_odd when y is odd, mem_even otherwise
   wrs_pkg::height_type mem_even [wrs_pkg::WIDTH_MAX];
   wrs_pkg::height_type mem_odd  [wrs_pkg::WIDTH_MAX];
   wrs_pkg::height_type mem_prev [wrs_pkg::WIDTH_MAX];

   wrs_pkg::col_type col_m1;
   wrs_pkg::col_type col_p1;
   wrs_pkg::col_type even_a_addr;
   wrs_pkg::col_type odd_a_addr;

   wrs_pkg::height_type even_a_ff;
   wrs_pkg::height_type even_b_ff;
   wrs_pkg::height_type odd_a_ff;
   wrs_pkg::height_type odd_b_ff;
   wrs_pkg::height_type prev_rd_ff;
   logic                row_odd_ff;

   // neighbor addresses wrap at the row buffer size, border pixels ignore them
   assign col_m1 = col - wrs_pkg::COL_BITS'(1);
   assign col_p1 = col + wrs_pkg::COL_BITS'(1);

   // port a reads the row above at x-1, or the row two above at x
   assign even_a_addr = row_odd ? col_m1 : col;
   assign odd_a_addr  = row_odd ? col : col_m1;

   // even row memory, read before write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         even_a_ff <= mem_even[even_a_addr];
         even_b_ff <= mem_even[col_p1];
      end
      if (wr_en && !row_odd) begin
         mem_even[col] <= cur_height;
      end
   end

   // odd row memory, read before write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         odd_a_ff <= mem_odd[odd_a_addr];
         odd_b_ff <= mem_odd[col_p1];
      end
      if (wr_en && row_odd) begin
         mem_odd[col] <= cur_height;
      end
   end

   // previous frame row, read before write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         prev_rd_ff <= mem_prev[col];
         row_odd_ff <= row_odd;
      end
      if (wr_en) begin
         mem_prev[col] <= prev_height;
      end
   end

   // pick the row above and the row two above by row parity
   always_comb begin
      if (row_odd_ff) begin
         window.left  = even_a_ff;
         window.right = even_b_ff;
         window.up    = odd_a_ff;
      end else begin
         window.left  = odd_a_ff;
         window.right = odd_b_ff;
         window.up    = even_a_ff;
      end
      window.prev = prev_rd_ff;
   end

endmodule

`default_nettype wire

@@ rtl/wrs_stencil.sv @@
// ----------------------------------------------------------------------------
// wrs_stencil
// four-neighbor sum, floor halving and previous-height subtract, registered
// ----------------------------------------------------------------------------
`default_nettype none

module wrs_stencil (
   input  wire                     clock,
   input  wire                     en,
   input  wrs_pkg::window_type     window,
   input  wrs_pkg::height_type     down,
   output wrs_pkg::diff_type       diff
);

   localparam int EXT = wrs_pkg::DIFF_BITS - wrs_pkg::HEIGHT_BITS;

   wrs_pkg::diff_type sum;
   wrs_pkg::diff_type half;
   wrs_pkg::diff_type diff_in;
   wrs_pkg::diff_type diff_ff;

   // sign-extended neighbor sum, arithmetic shift floors the halving
   always_comb begin
      sum = $signed({{EXT{window.left[wrs_pkg::HEIGHT_BITS-1]}}, window.left})
          + $signed({{EXT{window.right[wrs_pkg::HEIGHT_BITS-1]}}, window.right})
          + $signed({{EXT{window.up[wrs_pkg::HEIGHT_BITS-1]}}, window.up})
          + $signed({{EXT{down[wrs_pkg::HEIGHT_BITS-1]}}, down});
      half    = sum >>> 1;
      diff_in = half - $signed({{EXT{window.prev[wrs_pkg::HEIGHT_BITS-1]}}, window.prev});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff <= diff_in;
      end
   end

   assign diff = diff_ff;

endmodule

`default_nettype wire

@@ rtl/wrs_damp.sv @@
// ----------------------------------------------------------------------------
// wrs_damp
// damping multiply (registered), then truncation toward zero and saturation
// ----------------------------------------------------------------------------
`default_nettype none

module wrs_damp (
   input  wire                               clock,
   input  wire                               en,
   input  wrs_pkg::diff_type                 diff,
   input  wire [wrs_pkg::DAMP_BITS-1:0]      damping,
   output wrs_pkg::height_type               height
);

   localparam int PB = wrs_pkg::PROD_BITS;
   localparam int DB = wrs_pkg::DIFF_BITS;
   localparam int FB = wrs_pkg::DAMP_BITS;

   localparam logic signed [PB-1:0] Q_MAX  = PB'(wrs_pkg::SAT_HI);
   localparam logic signed [PB-1:0] Q_MIN  = PB'(wrs_pkg::SAT_LO);
   localparam logic signed [PB-1:0] RND_UP = PB'((2 ** FB) - 1);

   wrs_pkg::prod_type prod_in;
   wrs_pkg::prod_type prod_ff;
   wrs_pkg::prod_type biased;
   wrs_pkg::prod_type quot;

   // signed difference times unsigned q0.16 factor
   assign prod_in = $signed({{(PB-DB){diff[DB-1]}}, diff})
                  * $signed({{(PB-FB){1'b0}}, damping});

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   // bias negatives so the shift truncates toward zero
   always_comb begin
      biased = prod_ff + (prod_ff[PB-1] ? RND_UP : '0);
      quot   = biased >>> FB;
   end

   // clip to the height range
   always_comb begin
      if (quot > Q_MAX) begin
         height = Q_MAX[wrs_pkg::HEIGHT_BITS-1:0];
      end else if (quot < Q_MIN) begin
         height = Q_MIN[wrs_pkg::HEIGHT_BITS-1:0];
      end else begin
         height = quot[wrs_pkg::HEIGHT_BITS-1:0];
      end
   end

endmodule

`default_nettype wire

@@ dv/water_ripple_stencil_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// water ripple stencil checker
// watches the pixel, result and register channels, predicts every updated
// height from its own line stores and compares it with the block's output
// ----------------------------------------------------------------------------
module water_ripple_stencil_checker (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   input  wire                               req_tready,
   input  wire [31:0]                        req_tdata,
   input  wire                               rsp_tvalid,
   input  wire                               rsp_tready,
   input  wire [15:0]                        rsp_tdata,
   input  wire                               rsp_tlast,
   input  wire                               csr_valid,
   input  wire                               csr_ready,
   input  wire [wrs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire [wrs_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                fail_count,
   output int                                pending_count
);

   typedef struct packed {
      wrs_pkg::height_type height;
      logic                last_flag;
   } ripple_out_type;

   // shadow registers
   wrs_pkg::size_type             width_reg;
   wrs_pkg::size_type             height_reg;
   logic [wrs_pkg::DAMP_BITS-1:0] damping_reg;

   // two rows of current heights, one row of previous heights
   wrs_pkg::height_type cur_rows [0:2*wrs_pkg::WIDTH_MAX-1];
   wrs_pkg::height_type prev_row [0:wrs_pkg::WIDTH_MAX-1];
   int unsigned         col_pos;
   int unsigned         row_pos;

   ripple_out_type expected_heights [$];
   ripple_out_type oldest;
   int             mismatches = 0;

   function automatic int unsigned clamp_dim(input wrs_pkg::size_type v,
                                             input int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
   endfunction

   // advance the raster position by one pixel and queue the result it causes
   function automatic void predict_pixel(input wrs_pkg::height_type cur,
                                         input wrs_pkg::height_type prev);
      int unsigned    w;
      int unsigned    h;
      int unsigned    x;
      int unsigned    y;
      int unsigned    now_base;
      int unsigned    up_base;
      longint         total;
      longint         diff;
      longint         prod;
      longint         q;
      longint         sat_hi;
      ripple_out_type r;
      w        = clamp_dim(width_reg, wrs_pkg::WIDTH_MAX);
      h        = clamp_dim(height_reg, wrs_pkg::ROWS_MAX);
      x        = col_pos % wrs_pkg::WIDTH_MAX;
      y        = row_pos % wrs_pkg::ROWS_MAX;
      now_base = (y % 2) * wrs_pkg::WIDTH_MAX;
      up_base  = ((y + 1) % 2) * wrs_pkg::WIDTH_MAX;
      sat_hi   = (longint'(1) <<< (wrs_pkg::HEIGHT_BITS - 1)) - 1;
      if (y >= 1) begin
         if (x >= 1 && x + 1 < w && y >= 2) begin
            // four-neighbor sum, floor halving, minus previous height
            total = longint'(cur_rows[up_base + x - 1]) + longint'(cur_rows[up_base + x + 1])
                  + longint'(cur_rows[now_base + x]) + longint'(cur);
            diff  = (total >>> 1) - longint'(prev_row[x]);
            prod  = diff * longint'({48'd0, damping_reg});
            // damping product truncates toward zero
            if (prod >= 0) begin
               q = prod >>> wrs_pkg::DAMP_BITS;
            end else begin
               q = -((-prod) >>> wrs_pkg::DAMP_BITS);
            end
            if (q > sat_hi) q = sat_hi;
            if (q < -sat_hi - 1) q = -sat_hi - 1;
            r.height = wrs_pkg::height_type'(q);
         end else begin
            r.height = prev_row[x];
         end
         r.last_flag = (x + 1 >= w) && (y + 1 >= h);
         expected_heights.push_back(r);
      end
      cur_rows[now_base + x] = cur;
      prev_row[x]            = prev;
      if (x + 1 >= w) begin
         col_pos = 0;
         row_pos = (y + 1 >= h) ? 0 : y + 1;
      end else begin
         col_pos = x + 1;
         row_pos = y;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         width_reg   = wrs_pkg::FRAME_WIDTH_RST;
         height_reg  = wrs_pkg::FRAME_HEIGHT_RST;
         damping_reg = wrs_pkg::DAMPING_RST;
         col_pos     = 0;
         row_pos     = 0;
         expected_heights.delete();
      end else begin
         // compare result transaction against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (expected_heights.size() == 0) begin
               $error("unexpected result: new_height %0d last_of_frame %0b",
                      $signed(rsp_tdata), rsp_tlast);
               mismatches++;
            end else begin
               oldest = expected_heights.pop_front();
               if (rsp_tdata !== oldest.height) begin
                  $error("new_height mismatch: expected %0d, actual %0d",
                         oldest.height, $signed(rsp_tdata));
                  mismatches++;
               end
               if (rsp_tlast !== oldest.last_flag) begin
                  $error("last_of_frame mismatch: expected %0b, actual %0b",
                         oldest.last_flag, rsp_tlast);
                  mismatches++;
               end
            end
         end
         // pixel transaction
         if (req_tvalid && req_tready) begin
            predict_pixel(wrs_pkg::height_type'(req_tdata[15:0]),
                          wrs_pkg::height_type'(req_tdata[31:16]));
         end
         // register write
         if (csr_valid && csr_ready) begin
            case (csr_index)
               wrs_pkg::REG_FRAME_WIDTH:  width_reg   = csr_wdata[wrs_pkg::SIZE_BITS-1:0];
               wrs_pkg::REG_FRAME_HEIGHT: height_reg  = csr_wdata[wrs_pkg::SIZE_BITS-1:0];
               wrs_pkg::REG_DAMPING:      damping_reg = csr_wdata[wrs_pkg::DAMP_BITS-1:0];
               default: ;
            endcase
         end
      end
      pending_count <= expected_heights.size();
      fail_count    <= mismatches;
   end

endmodule

@@ dv/tb_water_ripple_stencil_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// water ripple stencil step testbench
// streams height-field pixels through the block under several frame sizes and
// damping settings, with random idle and stall bursts, and lets the checker
// compare each updated height and end-of-frame flag
// ----------------------------------------------------------------------------
module tb_water_ripple_stencil_step;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [31:0]            req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [15:0]            rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid;
   logic                   csr_ready;
   wrs_pkg::reg_index_type csr_index;
   logic [15:0]            csr_wdata;

   int                     failures;
   int                     pending_results;

   // stimulus-side raster tracking, used to keep width growth at frame start
   int unsigned            line_len   = 640;
   int unsigned            frame_rows = 480;
   int unsigned            col_at     = 0;
   int unsigned            row_at     = 0;
   int unsigned            sent_items = 0;
   logic                   quiet     = 1'b0;
   logic                   long_hold = 1'b0;

   // directed frames: saturation high, saturation low, negative truncation
   wrs_pkg::height_type plan_cur [0:26] = '{
      32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
      -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
      7, -1, 5, -1, 9, -2, 0, -1, 0};
   wrs_pkg::height_type plan_prev [0:26] = '{
      -32768, 0, 32767, -1, -32768, 1, 123, 456, -789,
      32767, -1, -32768, 0, 32767, -2, 0, 0, 0,
      1, 2, 3, 4, 0, 6, 0, 0, 0};

   water_ripple_stencil_step dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [15:0] cur_height, [31:16] prev_height
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [15:0] new_height
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   water_ripple_stencil_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (failures),
      .pending_count (pending_results)
   );

   // 10 ns clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // result side: random stall bursts, plus one long hold-off on request
   initial begin : result_sink
      int gap;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_tready = 1'b0;
            repeat (90) @(negedge clock);
            long_hold  = 1'b0;
            rsp_tready = 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap - 1) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   function automatic int unsigned used_size(input logic [10:0] v, input int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic wrs_pkg::height_type any_height();
      case ($urandom_range(0, 7))
         0, 1:    return wrs_pkg::height_type'($urandom);
         2: begin
            case ($urandom_range(0, 3))
               0:       return 16'sh7fff;
               1:       return 16'sh8000;
               2:       return 16'sh0000;
               default: return 16'shffff;
            endcase
         end
         default: return wrs_pkg::height_type'($urandom_range(0, 400) - 200);
      endcase
   endfunction

   // one pixel transaction, entered and left at a falling edge
   task automatic send_pixel(input wrs_pkg::height_type cur, input wrs_pkg::height_type prev);
      int gap;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid = 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {prev, cur};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      sent_items++;
      if (col_at + 1 >= line_len) begin
         col_at = 0;
         row_at = (row_at + 1 >= frame_rows) ? 0 : row_at + 1;
      end else begin
         col_at++;
      end
   endtask

   task automatic send_random(input int unsigned count);
      repeat (count) send_pixel(any_height(), any_height());
   endtask

   // complete the frame in progress so the raster is back at its origin
   task automatic finish_frame();
      while (col_at != 0 || row_at != 0) send_pixel(any_height(), any_height());
   endtask

   // stop sending, wait for every predicted result and the pipe to empty
   task automatic drain();
      req_tvalid = 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input wrs_pkg::reg_index_type idx, input logic [15:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
      case (idx)
         wrs_pkg::REG_FRAME_WIDTH:  line_len   = used_size(value[10:0], wrs_pkg::WIDTH_MAX);
         wrs_pkg::REG_FRAME_HEIGHT: frame_rows = used_size(value[10:0], wrs_pkg::ROWS_MAX);
         default: ;
      endcase
   endtask

   initial begin : stimulus
      int unsigned phase_no;
      int unsigned count;
      logic [15:0] damp;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = wrs_pkg::REG_FRAME_WIDTH;
      csr_wdata  = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset geometry: one full row and a bit, then shrink mid-frame
      send_random(650);
      drain();
      write_reg(wrs_pkg::REG_FRAME_WIDTH, 16'd4);
      write_reg(wrs_pkg::REG_FRAME_HEIGHT, 16'd3);
      finish_frame();

      // directed 3x3 frames: both saturation limits, then truncation of a
      // negative product with out-of-range sizes clamped up to the minimum
      drain();
      write_reg(wrs_pkg::REG_FRAME_WIDTH, 16'd3);
      write_reg(wrs_pkg::REG_DAMPING, 16'hffff);
      for (int i = 0; i < 18; i++) send_pixel(plan_cur[i], plan_prev[i]);
      drain();
      write_reg(wrs_pkg::REG_FRAME_WIDTH, 16'd0);
      write_reg(wrs_pkg::REG_FRAME_HEIGHT, 16'd1);
      write_reg(wrs_pkg::REG_DAMPING, 16'h8000);
      for (int i = 18; i < 27; i++) send_pixel(plan_cur[i], plan_prev[i]);

      // back-pressure: long receiver hold-off, then a full drain mid-frame
      drain();
      write_reg(wrs_pkg::REG_FRAME_WIDTH, 16'd8);
      write_reg(wrs_pkg::REG_FRAME_HEIGHT, 16'd6);
      write_reg(wrs_pkg::REG_DAMPING, wrs_pkg::DAMPING_RST);
      send_random(10);
      long_hold = 1'b1;
      send_random(40);
      drain();
      send_random(5);
      finish_frame();

      // random frames, sometimes with a mid-frame size or damping change
      phase_no = 0;
      while (sent_items < 900) begin
         drain();
         case ($urandom_range(0, 9))
            0:       write_reg(wrs_pkg::REG_FRAME_WIDTH, 16'($urandom_range(0, 2)));
            1:       write_reg(wrs_pkg::REG_FRAME_WIDTH, 16'($urandom_range(13, 24)));
            default: write_reg(wrs_pkg::REG_FRAME_WIDTH, 16'($urandom_range(3, 12)));
         endcase
         if ($urandom_range(0, 7) == 0) begin
            write_reg(wrs_pkg::REG_FRAME_HEIGHT, 16'($urandom_range(0, 2)));
         end else begin
            write_reg(wrs_pkg::REG_FRAME_HEIGHT, 16'($urandom_range(3, 6)));
         end
         case (phase_no)
            0:       damp = 16'h0000;
            1:       damp = 16'hffff;
            default: damp = 16'($urandom);
         endcase
         write_reg(wrs_pkg::REG_DAMPING, damp);
         count = $urandom_range(1, 2 * line_len * frame_rows);
         if (count > 60) count = 60;
         send_random(count);
         if ($urandom_range(0, 1) == 0) begin
            // only shrink the width mid-frame, height and damping go anywhere
            drain();
            write_reg(wrs_pkg::REG_FRAME_HEIGHT, 16'($urandom_range(0, 8)));
            if ($urandom_range(0, 1) == 0) begin
               write_reg(wrs_pkg::REG_FRAME_WIDTH, 16'($urandom_range(0, line_len)));
            end
            write_reg(wrs_pkg::REG_DAMPING, 16'($urandom));
         end
         if (sent_items >= 840) quiet = 1'b1;
         finish_frame();
         phase_no++;
      end

      // wait out the tail and give the verdict
      drain();
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
